// File: sv/plr_pkg.sv
`default_nettype none

package plr_pkg;

    localparam int FIELD_WORDS    = 3;
    localparam int KEY_BITS       = 64;
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_KEY_WORDS  = 3;
    localparam int POS_BITS       = 8;
    localparam int OUT_POS_BITS   = 7;
    localparam int CMD_BITS       = 3;
    localparam int STATUS_BITS    = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INSERT      = 3'd0,
        CMD_REMOVE      = 3'd1,
        CMD_FIND_NAME   = 3'd2,
        CMD_FIND_NUMBER = 3'd3,
        CMD_COUNT       = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_MISS = 2'd2
    } status_t;

    typedef struct packed {
        logic [CMD_BITS-1:0] cmd;
        logic [POS_BITS-1:0] position;
        logic [KEY_BITS-1:0] number_word0;
        logic [KEY_BITS-1:0] number_word1;
        logic [KEY_BITS-1:0] number_word2;
        logic [KEY_BITS-1:0] name_word0;
        logic [KEY_BITS-1:0] name_word1;
        logic [KEY_BITS-1:0] name_word2;
    } request_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0]  status;
        logic [OUT_POS_BITS-1:0] found_position;
        logic [KEY_BITS-1:0]     found_number_word0;
        logic [KEY_BITS-1:0]     found_number_word1;
        logic [KEY_BITS-1:0]     found_number_word2;
        logic [KEY_BITS-1:0]     found_name_word0;
        logic [KEY_BITS-1:0]     found_name_word1;
        logic [KEY_BITS-1:0]     found_name_word2;
        logic [OUT_POS_BITS-1:0] record_count;
    } response_t;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic fill;
        logic post;
    } ctl_t;

    typedef struct packed {
        logic skip_walk;
        logic is_insert;
        logic walk_done;
        logic hit;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// File: sv/plr_stream_if.sv
`default_nettype none

interface plr_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/positional_record_list.sv
// Records walked: count - position + 1 for insert, count - position for remove, count for a find
//   miss, j for a find hit at record j, and none for a refusal or a count command.
// Throughput: one command at a time; the next request is taken in the cycle after the
//   response is posted. The memory walk moves one record per cycle while a command runs.
//   A stalled response holds the result until the response beat is free.
// Reset: rst_n clears the record count and control state; memory contents are kept.
`default_nettype none

module positional_record_list
    import plr_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WORDS = DEF_KEY_WORDS
) (
    input wire           clk,
    input wire           rst_n,
    plr_stream_if.sink   request,
    plr_stream_if.source response
);

    ctl_t ctl;
    sts_t sts;

    plr_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    plr_datapath #(
        .CAPACITY  (CAPACITY),
        .KEY_WORDS (KEY_WORDS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (request.data),
        .ctl       (ctl),
        .sts       (sts),
        .rsp_valid (response.valid),
        .rsp_data  (response.data),
        .rsp_ready (response.ready)
    );

`ifndef NO_ASSERTIONS
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.load, ctl.start, ctl.step, ctl.fill, ctl.post}))
        else $error("controller issued more than one command");

    a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.post |-> sts.out_free)
        else $error("result posted over an untaken response beat");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> !request.ready)
        else $error("request taken while a command is in flight");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && (response.data.found_position != '0))
        |-> (response.data.status == ST_OK))
        else $error("found position reported without ok status");
`endif

endmodule

`default_nettype wire

// File: sv/plr_controller.sv
`default_nettype none

module plr_controller
    import plr_pkg::*;
(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  req_valid,
    output logic req_ready,
    input  sts_t sts,
    output ctl_t ctl
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_WALK   = 5'b00100,
        S_FILL   = 5'b01000,
        S_POST   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ctl.start  = 1'b1;
                state_next = sts.skip_walk ? S_POST : S_WALK;
            end
            S_WALK:
            begin
                ctl.step = 1'b1;
                if (sts.hit)
                begin
                    state_next = S_POST;
                end
                else if (sts.walk_done)
                begin
                    state_next = sts.is_insert ? S_FILL : S_POST;
                end
            end
            S_FILL:
            begin
                ctl.fill   = 1'b1;
                state_next = S_POST;
            end
            S_POST:
            begin
                if (sts.out_free)
                begin
                    ctl.post   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/plr_datapath.sv
`default_nettype none

module plr_datapath
    import plr_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WORDS = DEF_KEY_WORDS
) (
    input  wire       clk,
    input  wire       rst_n,
    input  request_t  req_data,
    input  ctl_t      ctl,
    output sts_t      sts,
    output logic      rsp_valid,
    output response_t rsp_data,
    input  wire       rsp_ready
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_BITS) ? CW : POS_BITS) + 1;
    localparam int FW = (CW > OUT_POS_BITS) ? CW : OUT_POS_BITS;
    localparam int LW = (KEY_WORDS < FIELD_WORDS) ? KEY_WORDS : FIELD_WORDS;

    typedef logic [KEY_WORDS-1:0][KEY_BITS-1:0] key_t;

    typedef struct packed {
        key_t num;
        key_t nam;
    } rec_t;

    logic [CMD_BITS-1:0] cmd_reg;
    logic [POS_BITS-1:0] pos_reg;
    rec_t                key_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       walk_idx_reg, pend_idx_reg;
    logic [CW-1:0]       left_reg;
    logic                pend_reg;
    rec_t                mem [CAPACITY];
    rec_t                rdata_reg;
    logic [STATUS_BITS-1:0]  res_status_reg;
    logic [OUT_POS_BITS-1:0] res_pos_reg;
    rec_t                res_rec_reg;
    logic                rsp_valid_reg;
    response_t           rsp_reg;

    logic [FIELD_WORDS-1:0][KEY_BITS-1:0] in_num, in_nam, out_num, out_nam;
    rec_t                load_rec;
    logic [PW-1:0]       pos_ext, cnt_ext;
    logic [CW-1:0]       pos_cw;
    logic                is_ins, is_rem, is_fname, is_fnum, is_find, is_cnt;
    logic                ins_ok, rem_ok, walk_ok;
    logic [STATUS_BITS-1:0] dec_status;
    logic [CW-1:0]       start_left;
    logic [AW-1:0]       start_idx;
    logic                issue, match, hit, walk_done;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    rec_t                wr_data;
    logic [FW-1:0]       found_full, cnt_full;

    assign in_num = {req_data.number_word2, req_data.number_word1, req_data.number_word0};
    assign in_nam = {req_data.name_word2, req_data.name_word1, req_data.name_word0};

    always_comb
    begin
        load_rec = '0;
        for (int w = 0; w < LW; w++)
        begin
            load_rec.num[w] = in_num[w];
            load_rec.nam[w] = in_nam[w];
        end
    end

    assign is_ins   = (cmd_reg == CMD_INSERT);
    assign is_rem   = (cmd_reg == CMD_REMOVE);
    assign is_fname = (cmd_reg == CMD_FIND_NAME);
    assign is_fnum  = (cmd_reg == CMD_FIND_NUMBER);
    assign is_cnt   = (cmd_reg == CMD_COUNT);
    assign is_find  = is_fname || is_fnum;

    assign pos_ext = PW'(pos_reg);
    assign cnt_ext = PW'(count_reg);
    assign pos_cw  = pos_ext[CW-1:0];
    assign ins_ok  = (cnt_ext < PW'(CAPACITY)) && (pos_ext != '0)
                     && (pos_ext <= cnt_ext + PW'(1));
    assign rem_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign walk_ok = (is_ins && ins_ok) || (is_rem && rem_ok) || is_find;

    always_comb
    begin
        priority if (is_ins)
        begin
            dec_status = ins_ok ? ST_OK : ST_BAD;
            start_left = count_reg - pos_cw + CW'(1);
            start_idx  = AW'(count_reg - CW'(1));
        end
        else if (is_rem)
        begin
            dec_status = rem_ok ? ST_OK : ST_BAD;
            start_left = count_reg - pos_cw;
            start_idx  = AW'(pos_cw);
        end
        else if (is_find)
        begin
            dec_status = ST_MISS;
            start_left = count_reg;
            start_idx  = '0;
        end
        else
        begin
            dec_status = is_cnt ? ST_OK : ST_BAD;
            start_left = '0;
            start_idx  = '0;
        end
    end

    assign issue     = ctl.step && (left_reg != '0);
    assign match     = is_fname ? (rdata_reg.nam == key_reg.nam)
                                : (rdata_reg.num == key_reg.num);
    assign hit       = pend_reg && is_find && match;
    assign walk_done = (left_reg == '0) && !pend_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rdata_reg;
        if (ctl.fill)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(pos_cw - CW'(1));
            wr_data = key_reg;
        end
        else if (ctl.step && pend_reg && (is_ins || is_rem))
        begin
            wr_en   = 1'b1;
            wr_addr = is_ins ? (pend_idx_reg + AW'(1)) : (pend_idx_reg - AW'(1));
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.fill)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.step && walk_done && is_rem)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign sts.skip_walk = !walk_ok;
    assign sts.is_insert = is_ins;
    assign sts.walk_done = walk_done;
    assign sts.hit       = hit;
    assign sts.out_free  = !rsp_valid_reg || rsp_ready;

    assign found_full = FW'(pend_idx_reg) + FW'(1);
    assign cnt_full   = FW'(count_reg);

    always_comb
    begin
        out_num = '0;
        out_nam = '0;
        for (int w = 0; w < LW; w++)
        begin
            out_num[w] = res_rec_reg.num[w];
            out_nam[w] = res_rec_reg.nam[w];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rdata_reg <= mem[walk_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= req_data.cmd;
            pos_reg <= req_data.position;
            key_reg <= load_rec;
        end
        if (ctl.start)
        begin
            res_status_reg <= dec_status;
            res_pos_reg    <= '0;
            res_rec_reg    <= '0;
        end
        else if (ctl.step && hit)
        begin
            res_status_reg <= ST_OK;
            res_pos_reg    <= found_full[OUT_POS_BITS-1:0];
            res_rec_reg    <= rdata_reg;
        end
        if (ctl.post)
        begin
            rsp_reg.status             <= res_status_reg;
            rsp_reg.found_position     <= res_pos_reg;
            rsp_reg.found_number_word0 <= out_num[0];
            rsp_reg.found_number_word1 <= out_num[1];
            rsp_reg.found_number_word2 <= out_num[2];
            rsp_reg.found_name_word0   <= out_nam[0];
            rsp_reg.found_name_word1   <= out_nam[1];
            rsp_reg.found_name_word2   <= out_nam[2];
            rsp_reg.record_count       <= cnt_full[OUT_POS_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            walk_idx_reg  <= '0;
            pend_idx_reg  <= '0;
            left_reg      <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (ctl.start)
            begin
                walk_idx_reg <= start_idx;
                left_reg     <= start_left;
                pend_reg     <= 1'b0;
            end
            else if (ctl.step)
            begin
                pend_reg <= issue;
                if (issue)
                begin
                    pend_idx_reg <= walk_idx_reg;
                    left_reg     <= left_reg - CW'(1);
                    walk_idx_reg <= is_ins ? (walk_idx_reg - AW'(1))
                                           : (walk_idx_reg + AW'(1));
                end
            end
            if (ctl.post)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

`default_nettype wire
